// File: src/fsdd_pkg.sv
// Shared types, command codes and segment fonts for the segment display driver.
package fsdd_pkg;

    localparam logic [1:0] CMD_SERIAL  = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_MEASURE = 2'd2;

    localparam logic [7:0] CAL_BYTE       = 8'd255;
    localparam logic [7:0] LOAD_THRESHOLD = 8'd100;
    localparam logic [7:0] LOAD_SCALE     = 8'd100;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
    } in_t;

    typedef struct packed {
        logic [6:0] segments;
        logic [3:0] digit_enable;
        logic [7:0] spi_reply;
        logic [7:0] pwm_duty;
    } out_t;

    typedef logic [3:0][3:0] digits_t;

    // bit0 A through bit6 G
    function automatic logic [6:0] digit_font(input logic [3:0] d);
        logic [6:0] seg;
        begin
            unique case (d)
                4'd0:    seg = 7'h3F;
                4'd1:    seg = 7'h06;
                4'd2:    seg = 7'h5B;
                4'd3:    seg = 7'h4F;
                4'd4:    seg = 7'h66;
                4'd5:    seg = 7'h6D;
                4'd6:    seg = 7'h7D;
                4'd7:    seg = 7'h07;
                4'd8:    seg = 7'h7F;
                4'd9:    seg = 7'h6F;
                default: seg = 7'h00;
            endcase
            return seg;
        end
    endfunction

    // C A L 1
    function automatic logic [6:0] cal_font(input logic [1:0] pos);
        logic [6:0] seg;
        begin
            unique case (pos)
                2'd0:    seg = 7'h39;
                2'd1:    seg = 7'h77;
                2'd2:    seg = 7'h38;
                default: seg = 7'h06;
            endcase
            return seg;
        end
    endfunction

endpackage

// File: src/fsdd_digits.sv
// Binary to four decimal digits of (number mod 10000), by parallel compare and subtract.
module fsdd_digits (
    input  logic [15:0]           number,
    output fsdd_pkg::digits_t     digits
);
    import fsdd_pkg::*;

    typedef struct packed {
        logic [3:0]  cnt;
        logic [15:0] rem;
    } split_t;

    // Largest k in 0..9 with k*unit <= value; the compares are independent.
    function automatic split_t split(input logic [15:0] value, input logic [15:0] unit);
        split_t     r;
        logic [16:0] thr;
        begin
            r.cnt = 4'd0;
            r.rem = value;
            for (int k = 1; k <= 9; k++) begin
                thr = 17'(k) * {1'b0, unit};
                if ({1'b0, value} >= thr) begin
                    r.cnt = 4'(k);
                    r.rem = value - thr[15:0];
                end
            end
            return r;
        end
    endfunction

    split_t s_mod;
    split_t s_thou;
    split_t s_hund;
    split_t s_tens;

    always_comb
    begin
        s_mod  = split(number, 16'd10000);
        s_thou = split(s_mod.rem, 16'd1000);
        s_hund = split(s_thou.rem, 16'd100);
        s_tens = split(s_hund.rem, 16'd10);
        digits[0] = s_thou.cnt;
        digits[1] = s_hund.cnt;
        digits[2] = s_tens.cnt;
        digits[3] = s_tens.rem[3:0];
    end

endmodule

// File: src/four_digit_segment_display_driver_core.sv
// Four-digit multiplexed seven-segment display driver core.
// Results: an item's result is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one item per cycle while the skid entry is empty; the one-entry skid takes an item while a result waits.
// Reset (rst_n low, asynchronous): number, digits, scan position, calibration,
// measurement and held pattern clear to zero; no result is pending.
module four_digit_segment_display_driver_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           src_valid,
    output logic           src_stall,
    input  fsdd_pkg::in_t  src_item,
    output logic           res_valid,
    input  logic           res_stall,
    output fsdd_pkg::out_t res_item
);
    import fsdd_pkg::*;

    logic [15:0] number_reg, number_next;
    digits_t     digits_reg, digits_next;
    logic [1:0]  pos_reg, pos_next;
    logic        cal_reg, cal_next;
    logic [7:0]  meas_reg, meas_next;
    logic [6:0]  seg_reg, seg_next;
    logic [3:0]  lit_reg, lit_next;

    logic        res_valid_reg, res_valid_next;
    out_t        res_reg, res_next;
    logic        skid_valid_reg, skid_valid_next;
    out_t        skid_reg, skid_next;

    logic        src_fire;
    logic        res_fire;
    logic [15:0] sum;
    digits_t     sum_digits;
    out_t        result;

    assign src_stall = skid_valid_reg;
    assign src_fire  = src_valid && !skid_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;
    assign res_fire  = res_valid_reg && !res_stall;

    assign sum = number_reg + 16'({8'd0, src_item.data} * {8'd0, LOAD_SCALE});

    fsdd_digits u_digits (
        .number (sum),
        .digits (sum_digits)
    );

    always_comb
    begin
        number_next = number_reg;
        digits_next = digits_reg;
        pos_next    = pos_reg;
        cal_next    = cal_reg;
        meas_next   = meas_reg;
        seg_next    = seg_reg;
        lit_next    = lit_reg;
        result.spi_reply = 8'd0;
        unique case (src_item.cmd)
            CMD_SERIAL:
            begin
                cal_next = (src_item.data == CAL_BYTE);
                if (src_item.data < LOAD_THRESHOLD)
                begin
                    number_next = {8'd0, src_item.data};
                end
                else
                begin
                    number_next = sum;
                    digits_next = sum_digits;
                end
                result.spi_reply = meas_reg;
            end
            CMD_TICK:
            begin
                seg_next = cal_reg ? cal_font(pos_reg) : digit_font(digits_reg[pos_reg]);
                lit_next = 4'b0001 << pos_reg;
                pos_next = pos_reg + 2'd1;
            end
            CMD_MEASURE:
            begin
                meas_next = src_item.data;
            end
            default:
            begin
                // unused code: report held outputs only
            end
        endcase
        result.segments     = seg_next;
        result.digit_enable = lit_next;
        result.pwm_duty     = meas_next;
    end

    // Output register with one skid entry behind it.
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (res_fire)
            begin
                res_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (src_fire)
        begin
            if (!res_valid_reg || res_fire)
            begin
                res_next       = result;
                res_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (res_fire)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_reg     <= 16'd0;
            digits_reg     <= '0;
            pos_reg        <= 2'd0;
            cal_reg        <= 1'b0;
            meas_reg       <= 8'd0;
            seg_reg        <= 7'd0;
            lit_reg        <= 4'd0;
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (src_fire)
            begin
                number_reg <= number_next;
                digits_reg <= digits_next;
                pos_reg    <= pos_next;
                cal_reg    <= cal_next;
                meas_reg   <= meas_next;
                seg_reg    <= seg_next;
                lit_reg    <= lit_next;
            end
            res_valid_reg  <= res_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        skid_reg <= skid_next;
    end

`ifndef SYNTHESIS
    a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> res_valid_reg)
        else $error("skid entry held with empty output register");

    a_tick_lights_one: assert property (@(posedge clk) disable iff (!rst_n)
        (src_fire && src_item.cmd == CMD_TICK) |=> $onehot(lit_reg))
        else $error("tick transfer did not light exactly one digit");

    a_enable_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> $onehot0(res_reg.digit_enable))
        else $error("result digit enable not one-hot");

    a_scan_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (src_fire && src_item.cmd == CMD_TICK) |=> (pos_reg == $past(pos_reg) + 2'd1))
        else $error("scan position did not advance on tick");
`endif

endmodule
